[src/hds_pkg.sv]
// Shared types and constants for the 1D heat diffusion stencil.
package hds_pkg;

  localparam int TEMP_W     = 16;  // Q3.12 temperature
  localparam int COEFF_W    = 16;  // Q0.16 diffusion coefficient
  localparam int STEPS_W    = 10;
  localparam int SIZE_W     = 7;
  localparam int LAP_W      = TEMP_W + 2;
  localparam int PROD_W     = COEFF_W + 1 + LAP_W;
  localparam int FRAC_SHIFT = 16;
  localparam int RND_W      = LAP_W + 1;
  localparam int SUM_W      = RND_W + 1;
  localparam int RND_HALF   = 32768;
  localparam int TEMP_MAX   = 32767;
  localparam int TEMP_MIN   = -32768;
  localparam int MIN_CELLS  = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS = 2'd2;

  localparam logic [COEFF_W-1:0] COEFF_RST = 16'd13107;
  localparam logic [STEPS_W-1:0] STEPS_RST = 10'd100;
  localparam logic [SIZE_W-1:0]  CELLS_RST = 7'd64;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [LAP_W-1:0]  lap_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SWEEP,
    ST_DRAIN,
    ST_EDGE_HI,
    ST_EDGE_LO,
    ST_EMIT,
    ST_EMIT_WAIT
  } hds_state_t;

endpackage

[src/hds_if.sv]
// Handshake channels of the heat diffusion stencil: cell input, result output, config writes.
interface hds_cell_if;
  import hds_pkg::*;
  logic  valid;
  logic  ready;
  temp_t cell_temp;
  modport source (output valid, output cell_temp, input ready);
  modport sink   (input valid, input cell_temp, output ready);
endinterface

interface hds_result_if;
  import hds_pkg::*;
  logic  valid;
  logic  ready;
  temp_t result_temp;
  logic  last_cell;
  modport source (output valid, output result_temp, output last_cell, input ready);
  modport sink   (input valid, input result_temp, input last_cell, output ready);
endinterface

interface hds_cfg_if;
  import hds_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/heat_diffusion_stencil_1d.sv]
// 1D FTCS heat diffusion stencil: grid memory, sweep pipeline and result output.
// Loading takes one word per cycle; the grid of n cells starts once the n-th word is in.
// Each sweep streams the grid through the single memory read port; after step_count sweeps
// the n words go out at one per cycle while result_out.ready stays high.
// Reset clears control state and restores register defaults; grid memory is not cleared.
module heat_diffusion_stencil_1d #(
  parameter int GRID_CELLS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  hds_cell_if.sink             cell_in,
  hds_result_if.source         result_out,
  hds_cfg_if.sink              cfg
);
  import hds_pkg::*;

  localparam int IDX_W = $clog2(GRID_CELLS);
  localparam int CNT_W = $clog2(GRID_CELLS + 1);
  localparam int SZ_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  // configuration registers
  logic [COEFF_W-1:0] coeff;
  logic [STEPS_W-1:0] step_count;
  logic [SIZE_W-1:0]  cells_in_use;

  hds_state_t state, state_next;

  logic [IDX_W-1:0]   load_index;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   n_m1;
  logic [IDX_W-1:0]   n_m2;
  logic [STEPS_W-1:0] sweeps_left;

  // grid memory
  logic [TEMP_W-1:0] mem [GRID_CELLS];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [TEMP_W-1:0] mem_wd;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_ra;
  logic [TEMP_W-1:0] mem_q;

  // sweep pipeline
  logic             v1, v2, v3, v4;
  logic [IDX_W-1:0] tag1, wa2, wa3, wa4;
  temp_t            win_l, win_c;
  temp_t            ctr2, ctr3, ctr4;
  lap_t             lap2;
  prod_t            prod3;
  prod_t            prod_bias;
  rnd_t             rnd4;
  sum_t             sum4;
  temp_t            new_val;
  temp_t            first_r, last_r;

  // output side
  logic  pend, pend_last, pend_move, emit_issue;
  logic  out_valid, out_last;
  temp_t out_temp;

  logic            in_acc;
  logic            load_done;
  logic [SZ_W-1:0] size_raw, grid_n;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff        <= COEFF_RST;
      step_count   <= STEPS_RST;
      cells_in_use <= CELLS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_COEFF: coeff        <= cfg.data[COEFF_W-1:0];
        CFG_STEPS: step_count   <= cfg.data[STEPS_W-1:0];
        CFG_CELLS: cells_in_use <= cfg.data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // grid size in force, clamped to the usable range
  always_comb begin
    size_raw = SZ_W'(cells_in_use);
    if (size_raw < SZ_W'(MIN_CELLS))       grid_n = SZ_W'(MIN_CELLS);
    else if (size_raw > SZ_W'(GRID_CELLS)) grid_n = SZ_W'(GRID_CELLS);
    else                                   grid_n = size_raw;
  end

  assign in_acc    = cell_in.valid && cell_in.ready;
  assign load_done = (SZ_W'(load_index) + SZ_W'(1)) >= grid_n;
  assign pend_move = pend && (!out_valid || result_out.ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_acc && load_done) state_next = (step_count == '0) ? ST_EMIT : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (rd_addr == n_m1) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!(v1 || v2 || v3 || v4)) state_next = ST_EDGE_HI;
      end
      ST_EDGE_HI: state_next = ST_EDGE_LO;
      ST_EDGE_LO: begin
        state_next = (sweeps_left == STEPS_W'(1)) ? ST_EMIT : ST_SWEEP;
      end
      ST_EMIT: begin
        if (emit_issue && rd_addr == n_m1) state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (!pend) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // memory port and handshake controls
  always_comb begin
    cell_in.ready = (state == ST_LOAD);
    emit_issue    = (state == ST_EMIT) && (!pend || pend_move);
    mem_we        = 1'b0;
    mem_wa        = load_index;
    mem_wd        = cell_in.cell_temp;
    mem_re        = 1'b0;
    mem_ra        = rd_addr;
    unique case (state)
      ST_LOAD: mem_we = in_acc;
      ST_SWEEP, ST_DRAIN: begin
        mem_re = (state == ST_SWEEP);
        mem_we = v4;
        mem_wa = wa4;
        mem_wd = new_val;
      end
      ST_EDGE_HI: begin
        mem_we = 1'b1;
        mem_wa = n_m1;
        mem_wd = last_r;
      end
      ST_EDGE_LO: begin
        mem_we = 1'b1;
        mem_wa = '0;
        mem_wd = first_r;
      end
      ST_EMIT: mem_re = emit_issue;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      load_index  <= '0;
      rd_addr     <= '0;
      sweeps_left <= '0;
      n_m1        <= '0;
      n_m2        <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (load_done) begin
          load_index  <= '0;
          sweeps_left <= step_count;
          n_m1        <= IDX_W'(grid_n - SZ_W'(1));
          n_m2        <= IDX_W'(grid_n - SZ_W'(2));
        end else begin
          load_index <= load_index + IDX_W'(1);
        end
      end
      if (state == ST_EDGE_LO) sweeps_left <= sweeps_left - STEPS_W'(1);
      if (state == ST_SWEEP) begin
        rd_addr <= (rd_addr == n_m1) ? '0 : rd_addr + IDX_W'(1);
      end else if (state == ST_EMIT) begin
        if (emit_issue) rd_addr <= rd_addr + IDX_W'(1);
      end else begin
        rd_addr <= '0;
      end
    end
  end

  // sweep pipeline: window, Laplacian, multiply, round, add and saturate
  always_comb begin
    prod_bias = prod3 + (prod3[PROD_W-1] ? PROD_W'(RND_HALF - 1) : PROD_W'(RND_HALF));
    sum4      = SUM_W'(ctr4) + SUM_W'(rnd4);
    if (sum4 > SUM_W'(TEMP_MAX))      new_val = temp_t'(TEMP_MAX);
    else if (sum4 < SUM_W'(TEMP_MIN)) new_val = temp_t'(TEMP_MIN);
    else                              new_val = TEMP_W'(sum4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= (state == ST_SWEEP);
      v2 <= v1 && (tag1 > IDX_W'(1));
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= rd_addr;
    if (v1) begin
      win_l <= win_c;
      win_c <= $signed(mem_q);
    end
    lap2  <= LAP_W'(win_l) - (LAP_W'(win_c) <<< 1) + LAP_W'($signed(mem_q));
    ctr2  <= win_c;
    wa2   <= tag1 - IDX_W'(1);
    prod3 <= PROD_W'($signed({1'b0, coeff})) * PROD_W'(lap2);
    ctr3  <= ctr2;
    wa3   <= wa2;
    rnd4  <= RND_W'(prod_bias >>> FRAC_SHIFT);
    ctr4  <= ctr3;
    wa4   <= wa3;
    // end cells copy their inner neighbors after the stream
    if (v4 && wa4 == IDX_W'(1)) first_r <= new_val;
    if (v4 && wa4 == n_m2)      last_r  <= new_val;
  end

  // read data waits in pend until the output word register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= emit_issue || (pend && !pend_move);
      if (pend_move)             out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_issue) pend_last <= (rd_addr == n_m1);
    if (pend_move) begin
      out_temp <= $signed(mem_q);
      out_last <= pend_last;
    end
  end

  assign result_out.valid       = out_valid;
  assign result_out.result_temp = out_temp;
  assign result_out.last_cell   = out_last;

`ifndef SYNTHESIS
  a_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD || state == ST_EDGE_HI) |-> !(v1 || v2 || v3 || v4))
    else $error("sweep pipeline busy outside a sweep");

  a_inner_write: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (wa4 != '0) && (wa4 < n_m1))
    else $error("sweep wrote an end cell");

  a_pend_emit: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ST_EMIT || state == ST_EMIT_WAIT))
    else $error("output read pending outside emission");
`endif

endmodule

[tb/heat_grid_checker.sv]
`timescale 1ns / 100ps
// Channel monitor for the stencil: tracks registers, predicts every emitted cell word and compares.
module heat_grid_checker #(
  parameter int GRID_CELLS = 64
) (
  input  logic  clk,
  input  logic  rst,
  hds_cell_if   cell_mon,
  hds_result_if result_mon,
  hds_cfg_if    cfg_mon,
  output int    fail_count,
  output int    pending
);
  import hds_pkg::*;

  typedef struct packed {
    temp_t temp;
    logic  last;
  } cell_word_t;

  logic [COEFF_W-1:0] coeff;
  logic [STEPS_W-1:0] sweeps;
  logic [SIZE_W-1:0]  size_reg;
  temp_t              heat [GRID_CELLS];
  int                 loaded;
  int                 fails;
  cell_word_t         expected_words [$];

  function automatic int active_cells(logic [SIZE_W-1:0] s);
    if (int'(s) < MIN_CELLS) return MIN_CELLS;
    if (int'(s) > GRID_CELLS) return GRID_CELLS;
    return int'(s);
  endfunction

  // One FTCS update of a single cell, Q3.12 in and out.
  function automatic temp_t diffuse_cell(temp_t left, temp_t mid, temp_t right);
    longint k, lap, flux, mag, next_t;
    k    = coeff;
    lap  = longint'(left) - 2 * longint'(mid) + longint'(right);
    flux = k * lap;
    // Q.28 product back to Q.12, ties away from zero
    mag    = (flux < 0) ? -flux : flux;
    mag    = (mag + RND_HALF) >>> FRAC_SHIFT;
    next_t = longint'(mid) + ((flux < 0) ? -mag : mag);
    if (next_t > TEMP_MAX) return temp_t'(TEMP_MAX);
    if (next_t < TEMP_MIN) return temp_t'(TEMP_MIN);
    return temp_t'(next_t);
  endfunction

  function automatic void run_sweeps(int n);
    temp_t fresh [GRID_CELLS];
    for (int s = 0; s < int'(sweeps); s++) begin
      for (int i = 1; i < n - 1; i++)
        fresh[i] = diffuse_cell(heat[i - 1], heat[i], heat[i + 1]);
      // reflective ends
      fresh[0]     = fresh[1];
      fresh[n - 1] = fresh[n - 2];
      for (int i = 0; i < n; i++) heat[i] = fresh[i];
    end
  endfunction

  always @(posedge clk) begin : monitor
    int         n;
    cell_word_t want;
    if (rst) begin
      coeff    = COEFF_RST;
      sweeps   = STEPS_RST;
      size_reg = CELLS_RST;
      loaded   = 0;
      fails    = 0;
      expected_words.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_COEFF: coeff    = cfg_mon.data;
          CFG_STEPS: sweeps   = cfg_mon.data[STEPS_W-1:0];
          CFG_CELLS: size_reg = cfg_mon.data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: result_temp %0d, last_cell %0b",
                 result_mon.result_temp, result_mon.last_cell);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (result_mon.result_temp !== want.temp) begin
            $error("result_temp: expected %0d, got %0d", want.temp, result_mon.result_temp);
            fails++;
          end
          if (result_mon.last_cell !== want.last) begin
            $error("last_cell: expected %0b, got %0b", want.last, result_mon.last_cell);
            fails++;
          end
        end
      end
      if (cell_mon.valid && cell_mon.ready) begin
        // size in force at this word; a size lowered mid-load fires at once
        n = active_cells(size_reg);
        if (loaded < GRID_CELLS) heat[loaded] = cell_mon.cell_temp;
        loaded++;
        if (loaded >= n) begin
          run_sweeps(n);
          for (int i = 0; i < n; i++) begin
            want.temp = heat[i];
            want.last = (i == n - 1);
            expected_words.push_back(want);
          end
          loaded = 0;
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_words.size();
  end

endmodule

[tb/heat_diffusion_stencil_1d_test.sv]
`timescale 1ns / 100ps
// Test top for the stencil: clock, reset, cell and register traffic, result stalls, verdict.
module heat_diffusion_stencil_1d_test;
  import hds_pkg::*;

  localparam int GRID_CELLS    = 64;
  localparam int RANDOM_WORDS  = 370;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 300000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  int                fail_count;
  int                pending;
  bit                steady_in;
  bit                steady_out;
  int                words_sent;
  logic [SIZE_W-1:0] size_now;

  hds_cell_if   cell_if ();
  hds_result_if result_if ();
  hds_cfg_if    cfg_if ();

  heat_diffusion_stencil_1d #(
    .GRID_CELLS(GRID_CELLS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cell_in    (cell_if),
    .result_out (result_if),
    .cfg        (cfg_if)
  );

  heat_grid_checker #(
    .GRID_CELLS(GRID_CELLS)
  ) grid_check (
    .clk        (clk),
    .rst        (rst),
    .cell_mon   (cell_if),
    .result_mon (result_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = int'($urandom_range(99));
    if (r < 45) return 0;
    if (r < 85) return int'($urandom_range(3, 1));
    if (r < 97) return int'($urandom_range(12, 4));
    return int'($urandom_range(60, 20));
  endfunction

  function automatic temp_t pick_temp();
    int r;
    r = int'($urandom_range(9));
    if (r < 5) return temp_t'($urandom);
    if (r < 7) begin
      case ($urandom_range(3))
        0: return temp_t'(TEMP_MAX);
        1: return temp_t'(TEMP_MIN);
        2: return temp_t'(0);
        default: return temp_t'(-1);
      endcase
    end
    return temp_t'(int'($urandom_range(2048)) - 1024);
  endfunction

  function automatic int grid_len(logic [SIZE_W-1:0] s);
    if (int'(s) < MIN_CELLS) return MIN_CELLS;
    if (int'(s) > GRID_CELLS) return GRID_CELLS;
    return int'(s);
  endfunction

  task automatic send_cell(temp_t t);
    int gap;
    gap = pick_gap(steady_in);
    if (gap > 0) begin
      cell_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_if.valid     <= 1'b1;
    cell_if.cell_temp <= t;
    do @(posedge clk); while (!cell_if.ready);
    words_sent++;
  endtask

  task automatic load_cells(int count);
    repeat (count) send_cell(pick_temp());
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_CELLS) size_now = value[SIZE_W-1:0];
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] k, logic [15:0] steps, logic [15:0] cells);
    write_reg(CFG_COEFF, k);
    write_reg(CFG_STEPS, steps);
    write_reg(CFG_CELLS, cells);
  endtask

  // Let every predicted word drain, then give the block time to go quiet.
  task automatic settle();
    cell_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_drain
    int gap;
    result_if.ready = 1'b0;
    steady_out      = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(39) == 0) steady_out = !steady_out;
      gap = pick_gap(steady_out);
      if (gap > 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk); while (!result_if.valid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (!rst);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cell_if.valid && cell_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("heat_diffusion_stencil_1d_test failed");
    $finish;
  end

  initial begin : stimulus
    int   grid;
    int   n;
    int   head;
    int   r;
    logic [15:0] k;
    logic [15:0] steps;
    logic [15:0] cells;
    cell_if.valid     = 1'b0;
    cell_if.cell_temp = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    size_now          = CELLS_RST;
    steady_in         = 1'b0;
    words_sent        = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero sweeps: grid comes back untouched
    configure(16'd32768, 16'd0, 16'd3);
    send_cell(temp_t'(TEMP_MAX));
    send_cell(temp_t'(TEMP_MIN));
    send_cell(temp_t'(0));
    settle();
    write_reg(CFG_STEPS, 16'd1);
    send_cell(temp_t'(TEMP_MIN));
    send_cell(temp_t'(TEMP_MAX));
    send_cell(temp_t'(TEMP_MIN));
    settle();
    // coefficient above one half on a checkerboard: saturates
    configure(16'hFFFF, 16'd3, 16'd4);
    send_cell(temp_t'(TEMP_MAX));
    send_cell(temp_t'(TEMP_MIN));
    send_cell(temp_t'(TEMP_MAX));
    send_cell(temp_t'(TEMP_MIN));
    settle();
    configure(16'd0, 16'd5, 16'd5);
    load_cells(5);
    settle();
    // size below the minimum clamps to three; spare index must not disturb anything
    configure(16'd13107, 16'd2, 16'd0);
    write_reg(CFG_SPARE, 16'hFFFF);
    load_cells(3);
    settle();
    // size lowered mid-load: next word fires the grid on its first three cells
    write_reg(CFG_CELLS, 16'd8);
    load_cells(5);
    settle();
    write_reg(CFG_CELLS, 16'hFF83);  // only the low seven bits count
    load_cells(1);
    settle();

    words_sent = 0;
    grid       = 0;
    while (words_sent < RANDOM_WORDS) begin
      steady_in = ($urandom_range(3) == 0);
      if (grid == 2) begin
        // slowest case: full grid, most sweeps
        settle();
        configure(16'd32768, 16'd1023, 16'd64);
      end else if (grid == 0 || grid == 5 || $urandom_range(9) < 6) begin
        r = int'($urandom_range(9));
        if (r < 7)      k = 16'($urandom_range(32768));
        else if (r < 9) k = ($urandom_range(1) == 0) ? 16'd0 : 16'd32768;
        else            k = 16'($urandom_range(65535, 32769));
        r = int'($urandom_range(9));
        if (r < 6)      steps = 16'($urandom_range(12));
        else if (r < 9) steps = 16'($urandom_range(100, 13));
        else            steps = 16'($urandom_range(400, 101));
        r = int'($urandom_range(9));
        if (grid == 5)  cells = 16'd127;
        else if (r < 6) cells = 16'($urandom_range(12, 3));
        else if (r < 8) cells = 16'($urandom_range(64, 13));
        else if (r < 9) cells = 16'($urandom_range(2));
        else            cells = 16'($urandom_range(127, 65));
        settle();
        configure(k, steps, cells);
      end
      n = grid_len(size_now);
      if ($urandom_range(7) == 0) begin
        head = int'($urandom_range(n - 1, 1));
        load_cells(head);
        settle();
        write_reg(CFG_CELLS, 16'($urandom_range(n, 3)));
        n = grid_len(size_now) - head;
        load_cells((n < 1) ? 1 : n);
      end else begin
        load_cells(n);
      end
      grid++;
    end

    settle();
    if (fail_count == 0)
      $display("heat_diffusion_stencil_1d_test passed");
    else
      $display("heat_diffusion_stencil_1d_test failed");
    $finish;
  end

endmodule
